>>> sv/rocauc_pkg.sv
// Shared types and constants for the ROC AUC engine.
package rocauc_pkg;

    localparam int SCORE_W = 32;
    localparam int MAX_ITEMS_DEF = 256;
    localparam int FRACTION_BITS_DEF = 16;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_WALK,
        ST_MUL,
        ST_START,
        ST_DIV
    } state_t;

    typedef struct packed {
        logic                      valid;
        logic                      positive;
        logic signed [SCORE_W-1:0] score;
    } cell_data_t;

    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctl_t;

endpackage

>>> sv/rocauc_cell.sv
// One cell of the sorted insertion chain; holds one score and label.
module rocauc_cell (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rocauc_pkg::cell_ctl_t                ctl,
    input  logic signed [rocauc_pkg::SCORE_W-1:0] new_score,
    input  logic                                 new_positive,
    input  logic                                 prev_take,
    input  rocauc_pkg::cell_data_t               prev_data,
    input  rocauc_pkg::cell_data_t               next_data,
    output logic                                 take,
    output rocauc_pkg::cell_data_t               data
);

    logic                                  valid_reg;
    logic                                  positive_reg;
    logic signed [rocauc_pkg::SCORE_W-1:0] score_reg;

    // A cell yields its place when it is empty or holds a strictly lower score.
    assign take = !valid_reg || (score_reg < new_score);

    assign data.valid    = valid_reg;
    assign data.positive = positive_reg;
    assign data.score    = score_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.insert) begin
            if (prev_take) begin
                valid_reg <= prev_data.valid;
            end else if (take) begin
                valid_reg <= 1'b1;
            end
        end else if (ctl.drain) begin
            valid_reg <= next_data.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.insert) begin
            if (prev_take) begin
                positive_reg <= prev_data.positive;
                score_reg    <= prev_data.score;
            end else if (take) begin
                positive_reg <= new_positive;
                score_reg    <= new_score;
            end
        end else if (ctl.drain) begin
            positive_reg <= next_data.positive;
            score_reg    <= next_data.score;
        end
    end

endmodule

>>> sv/rocauc_div.sv
// Restoring divider that yields a truncated fraction one bit per cycle.
module rocauc_div #(
    parameter int SUM_W = 18,
    parameter int FRACTION_BITS = rocauc_pkg::FRACTION_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [SUM_W-1:0]       num,
    input  logic [SUM_W-1:0]       den,
    output logic                   busy,
    output logic [FRACTION_BITS:0] quot
);

    localparam int CNT_W = $clog2(FRACTION_BITS + 2);

    logic [SUM_W:0]         rem_reg;
    logic [SUM_W-1:0]       den_reg;
    logic [FRACTION_BITS:0] quot_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   busy_reg;
    logic                   bit_ge;
    logic [SUM_W:0]         diff;
    logic [SUM_W-1:0]       rem_next;

    assign diff     = rem_reg - {1'b0, den_reg};
    assign bit_ge   = rem_reg >= {1'b0, den_reg};
    assign rem_next = bit_ge ? diff[SUM_W-1:0] : rem_reg[SUM_W-1:0];
    assign busy     = busy_reg;
    assign quot     = quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(FRACTION_BITS + 1);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= {1'b0, num};
            den_reg  <= den;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= {rem_next, 1'b0};
            quot_reg <= {quot_reg[FRACTION_BITS-1:0], bit_ge};
        end
    end

endmodule

>>> sv/binary_roc_auc_engine_unit.sv
// Top level of the ROC AUC engine: sorted insertion chain, rank-count walk and divide.
// Throughput: one word per cycle while a data set loads.
// After the last word is accepted, the chain drains through the rank-count walk, then
// the product of the class counts is registered, and the divider produces the fraction.
// The input stays stalled from the last word until the result is loaded for output.
// Reset (aresetn low, synchronous) empties the chain and clears counts and the output valid flag.
module binary_roc_auc_engine_unit #(
    parameter int MAX_ITEMS = rocauc_pkg::MAX_ITEMS_DEF,
    parameter int FRACTION_BITS = rocauc_pkg::FRACTION_BITS_DEF,
    localparam int MDATA_W = ((FRACTION_BITS + 1 + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rocauc_pkg::SCORE_W-1:0] s_tdata,  // score
    input  logic                           s_tuser,  // label_is_positive
    input  logic                           s_tlast,  // last_item
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [MDATA_W-1:0]             m_tdata,  // auc_fraction, zero padded
    output logic [1:0]                     m_tuser   // bit 1 capacity_overflow, bit 0 one_class_only
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = 2 * CW;

    rocauc_pkg::state_t     state_reg, state_next;
    rocauc_pkg::cell_ctl_t  ctl;
    rocauc_pkg::cell_data_t cell_q [MAX_ITEMS];
    logic                   take [MAX_ITEMS];

    logic [CW-1:0]          pos_reg, neg_reg, running_reg;
    logic [CW-1:0]          count;
    logic [SW-1:0]          sum_reg, den_reg;
    logic                   ovf_reg, one_class_reg;
    logic                   room, accept, div_start, out_load, div_busy;
    logic [FRACTION_BITS:0] quot;
    logic [FRACTION_BITS:0] auc_reg;
    logic                   m_one_reg, m_ovf_reg, m_valid_reg;

    assign count  = pos_reg + neg_reg;
    assign room   = count < CW'(MAX_ITEMS);
    assign accept = s_tvalid && s_tready;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
            logic                   p_take;
            rocauc_pkg::cell_data_t p_data;
            rocauc_pkg::cell_data_t n_data;
            if (gi == 0) begin : g_head
                assign p_take = 1'b0;
                assign p_data = cell_q[0];
            end else begin : g_body
                assign p_take = take[gi-1];
                assign p_data = cell_q[gi-1];
            end
            if (gi == MAX_ITEMS - 1) begin : g_tail
                assign n_data = '0;
            end else begin : g_mid
                assign n_data = cell_q[gi+1];
            end
            rocauc_cell u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .ctl          (ctl),
                .new_score    ($signed(s_tdata)),
                .new_positive (s_tuser),
                .prev_take    (p_take),
                .prev_data    (p_data),
                .next_data    (n_data),
                .take         (take[gi]),
                .data         (cell_q[gi])
            );
        end
    endgenerate

    rocauc_div #(
        .SUM_W         (SW),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (sum_reg),
        .den     (den_reg),
        .busy    (div_busy),
        .quot    (quot)
    );

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        ctl        = '0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            rocauc_pkg::ST_LOAD: begin
                s_tready   = 1'b1;
                ctl.insert = s_tvalid && room;
                if (s_tvalid && s_tlast) begin
                    state_next = rocauc_pkg::ST_WALK;
                end
            end
            rocauc_pkg::ST_WALK: begin
                if (cell_q[0].valid) begin
                    ctl.drain = 1'b1;
                end else begin
                    state_next = rocauc_pkg::ST_MUL;
                end
            end
            rocauc_pkg::ST_MUL: begin
                state_next = rocauc_pkg::ST_START;
            end
            rocauc_pkg::ST_START: begin
                div_start  = 1'b1;
                state_next = rocauc_pkg::ST_DIV;
            end
            rocauc_pkg::ST_DIV: begin
                if (!div_busy && (!m_valid_reg || m_tready)) begin
                    out_load   = 1'b1;
                    state_next = rocauc_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = rocauc_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rocauc_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            neg_reg     <= '0;
            ovf_reg     <= 1'b0;
            running_reg <= '0;
            sum_reg     <= '0;
        end else begin
            if (accept) begin
                if (!room) begin
                    ovf_reg <= 1'b1;
                end else if (s_tuser) begin
                    pos_reg <= pos_reg + 1'b1;
                end else begin
                    neg_reg <= neg_reg + 1'b1;
                end
            end
            if (ctl.drain) begin
                if (cell_q[0].positive) begin
                    running_reg <= running_reg + 1'b1;
                end else begin
                    sum_reg <= sum_reg + SW'(running_reg);
                end
            end
            if (out_load) begin
                pos_reg     <= '0;
                neg_reg     <= '0;
                ovf_reg     <= 1'b0;
                running_reg <= '0;
                sum_reg     <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == rocauc_pkg::ST_MUL) begin
            den_reg       <= SW'(pos_reg) * SW'(neg_reg);
            one_class_reg <= (pos_reg == '0) || (neg_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            auc_reg   <= one_class_reg ? '0 : quot;
            m_one_reg <= one_class_reg;
            m_ovf_reg <= ovf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = MDATA_W'(auc_reg);
    assign m_tuser  = {m_ovf_reg, m_one_reg};

endmodule

>>> sv/rocauc_chk.sv
// Port-level checker for the ROC AUC engine, bound to the top level.
module rocauc_chk #(
    parameter int FRACTION_BITS = rocauc_pkg::FRACTION_BITS_DEF,
    localparam int MDATA_W = ((FRACTION_BITS + 1 + 7) / 8) * 8
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [MDATA_W-1:0]             m_tdata,
    input logic [1:0]                     m_tuser
);

    localparam logic [MDATA_W-1:0] ONE = MDATA_W'(1) << FRACTION_BITS;

    a_hold_valid : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_one_class_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("single-class result carries a nonzero fraction");

    a_fraction_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata <= ONE)
        else $error("fraction exceeds one");

    a_stall_after_last : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken during evaluation");

endmodule

bind binary_roc_auc_engine_unit rocauc_chk #(
    .FRACTION_BITS (FRACTION_BITS)
) u_rocauc_chk (.*);

>>> tb/tb.sv
// Self-checking testbench for the ROC AUC engine: directed and random data sets against an in-bench predictor.
module tb;

    localparam int SCORE_W = rocauc_pkg::SCORE_W;
    localparam int AUC_W = rocauc_pkg::FRACTION_BITS_DEF + 1;
    localparam int MDATA_W = ((AUC_W + 7) / 8) * 8;
    localparam int TARGET_WORDS = 1650;
    localparam int LONG_HOLD_CYCLES = 3000;
    localparam int HOLD_AFTER_RESULTS = 15;
    localparam int TAIL_CYCLES = rocauc_pkg::MAX_ITEMS_DEF + rocauc_pkg::FRACTION_BITS_DEF + 40;

    typedef struct {
        logic [SCORE_W-1:0] score;
        logic               positive;
        logic               last;
        logic               hold;
    } pair_word_t;

    typedef struct {
        logic [AUC_W-1:0] auc;
        logic             one_class;
        logic             overflow;
    } auc_result_t;

    typedef enum {SCORE_WIDE, SCORE_NARROW, SCORE_EDGE} score_mode_t;
    typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [SCORE_W-1:0]  s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [MDATA_W-1:0]  m_tdata;
    logic [1:0]          m_tuser;

    pair_word_t          pending_pairs[$];
    auc_result_t         auc_expected[$];
    logic [SCORE_W-1:0]  set_scores[$];
    logic                set_labels[$];
    logic                set_overflow = 1'b0;
    logic                word_taken = 1'b0;
    int                  error_count = 0;
    int                  results_seen = 0;
    int                  words_queued = 0;

    binary_roc_auc_engine_unit dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic auc_result_t auc_from_ranks();
        auc_result_t     r;
        longint unsigned pairs;
        longint unsigned npos;
        longint unsigned nneg;
        pairs = 0;
        npos = 0;
        nneg = 0;
        for (int j = 0; j < set_scores.size(); j++) begin
            if (set_labels[j]) begin
                npos++;
            end else begin
                nneg++;
                for (int i = 0; i < set_scores.size(); i++) begin
                    if (set_labels[i] && ($signed(set_scores[i]) > $signed(set_scores[j]) ||
                        (set_scores[i] == set_scores[j] && i < j)))
                        pairs++;
                end
            end
        end
        r.one_class = (npos == 0 || nneg == 0);
        r.overflow = set_overflow;
        r.auc = r.one_class ? '0 :
                AUC_W'((pairs << rocauc_pkg::FRACTION_BITS_DEF) / (npos * nneg));
        return r;
    endfunction

    task automatic store_pair(input logic [SCORE_W-1:0] score, input logic positive,
                              input logic last);
        if (set_scores.size() >= rocauc_pkg::MAX_ITEMS_DEF) begin
            set_overflow = 1'b1;
        end else begin
            set_scores.push_back(score);
            set_labels.push_back(positive);
        end
        if (last) begin
            auc_expected.push_back(auc_from_ranks());
            set_scores.delete();
            set_labels.delete();
            set_overflow = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        auc_result_t exp_r;
        if (!aresetn) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                store_pair(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (auc_expected.size() == 0) begin
                    $error("result word with no expectation pending: auc_fraction %0d", m_tdata);
                    error_count++;
                end else begin
                    exp_r = auc_expected.pop_front();
                    if (m_tdata !== {{(MDATA_W-AUC_W){1'b0}}, exp_r.auc}) begin
                        $error("auc_fraction: expected %0d, got %0d", exp_r.auc, m_tdata);
                        error_count++;
                    end
                    if (m_tuser[0] !== exp_r.one_class) begin
                        $error("one_class_only: expected %0d, got %0d", exp_r.one_class,
                               m_tuser[0]);
                        error_count++;
                    end
                    if (m_tuser[1] !== exp_r.overflow) begin
                        $error("capacity_overflow: expected %0d, got %0d", exp_r.overflow,
                               m_tuser[1]);
                        error_count++;
                    end
                end
            end
        end
    end

    int burst_left = 1;
    int gap_left = 0;

    always @(negedge aclk) begin
        pair_word_t nxt;
        logic       offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
            s_tlast <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            offer = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_pairs.size() != 0 &&
                         !(pending_pairs[0].hold && auc_expected.size() != 0)) begin
                nxt = pending_pairs.pop_front();
                offer = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            s_tvalid <= offer;
            if (offer) begin
                s_tdata <= nxt.score;
                s_tuser <= nxt.positive;
                s_tlast <= nxt.last;
            end
        end
    end

    rx_mode_t rx_mode = RX_OPEN;
    int       rx_mode_left = 0;
    int       rx_hold_left = 0;
    bit       rx_hold_done = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (!rx_hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
                rx_hold_left = LONG_HOLD_CYCLES;
                rx_hold_done = 1'b1;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode = rx_mode_t'($urandom_range(0, 2));
                    rx_mode_left = $urandom_range(20, 200);
                end
                rx_mode_left--;
                case (rx_mode)
                    RX_OPEN: m_tready <= 1'b1;
                    RX_RANDOM: m_tready <= $urandom_range(0, 1);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic push_word(input logic [SCORE_W-1:0] score, input logic positive,
                             input logic last, input logic hold);
        pair_word_t w;
        w.score = score;
        w.positive = positive;
        w.last = last;
        w.hold = hold;
        pending_pairs.push_back(w);
        words_queued++;
    endtask

    function automatic logic [SCORE_W-1:0] pick_score(input score_mode_t mode);
        logic [SCORE_W-1:0] s;
        case (mode)
            SCORE_WIDE: s = $urandom;
            SCORE_NARROW: s = SCORE_W'($signed($urandom_range(0, 6)) - 3);
            default: begin
                case ($urandom_range(0, 5))
                    0: s = 32'h8000_0000;
                    1: s = 32'h7fff_ffff;
                    2: s = 32'h0000_0000;
                    3: s = 32'hffff_ffff;
                    4: s = 32'h8000_0001;
                    default: s = 32'h7fff_fffe;
                endcase
            end
        endcase
        return s;
    endfunction

    task automatic add_set(input int n, input int pos_pct, input logic hold);
        score_mode_t mode;
        mode = score_mode_t'($urandom_range(0, 2));
        for (int k = 0; k < n; k++)
            push_word(pick_score(mode), $urandom_range(0, 99) < pos_pct, k == n - 1,
                      hold && k == 0);
    endtask

    initial begin
        int n;
        int pct;
        int set_no;

        push_word(32'h7fff_ffff, 1'b1, 1'b1, 1'b0);
        push_word(32'h8000_0000, 1'b0, 1'b0, 1'b1);
        push_word(32'h7fff_ffff, 1'b1, 1'b1, 1'b0);
        push_word(32'h7fff_ffff, 1'b0, 1'b0, 1'b0);
        push_word(32'h8000_0000, 1'b1, 1'b1, 1'b0);
        push_word(32'd5, 1'b1, 1'b0, 1'b0);
        push_word(32'd5, 1'b0, 1'b0, 1'b0);
        push_word(32'd5, 1'b0, 1'b0, 1'b0);
        push_word(32'd5, 1'b1, 1'b1, 1'b0);
        push_word(32'h0000_0000, 1'b0, 1'b0, 1'b0);
        push_word(32'hffff_ffff, 1'b0, 1'b0, 1'b0);
        push_word(32'h8000_0000, 1'b0, 1'b1, 1'b0);
        push_word(32'hffff_ffff, 1'b1, 1'b0, 1'b1);
        push_word(32'h0000_0000, 1'b0, 1'b0, 1'b0);
        push_word(32'h0000_0001, 1'b1, 1'b0, 1'b0);
        push_word(32'h0000_0000, 1'b1, 1'b0, 1'b0);
        push_word(32'hffff_ffff, 1'b0, 1'b1, 1'b0);

        set_no = 0;
        while (words_queued < TARGET_WORDS) begin
            if (set_no == 8)
                n = rocauc_pkg::MAX_ITEMS_DEF;
            else if (set_no == 16)
                n = rocauc_pkg::MAX_ITEMS_DEF + 2;
            else if ($urandom_range(0, 9) == 0)
                n = $urandom_range(25, 60);
            else
                n = $urandom_range(1, 16);
            case ($urandom_range(0, 9))
                0: pct = 0;
                1: pct = 100;
                default: pct = $urandom_range(10, 90);
            endcase
            add_set(n, pct, set_no % 12 == 5);
            set_no++;
        end

        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        while (pending_pairs.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (auc_expected.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0 && auc_expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(12 * 600000);
        $display("FAIL");
        $finish;
    end

endmodule
